### src/ed3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_pkg
// Shared types, register and mode codes, and kernel coefficients of the
// 3x3 edge detector.
// ----------------------------------------------------------------------------
package ed3_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// operator codes
	localparam logic [1:0] MODE_SOBEL   = 2'd0;
	localparam logic [1:0] MODE_PREWITT = 2'd1;
	localparam logic [1:0] MODE_KIRSCH  = 2'd2;

	localparam int TAPS  = 9;
	localparam int NKERN = 8;
	localparam int NPAIR = 2;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [12:0] HEIGHT_MIN   = 13'd3;
	localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

	typedef logic [7:0]         pix_t;
	typedef logic signed [3:0]  coef_t;
	typedef logic signed [12:0] sum_t;

	// per-beat control that travels with the pixel down the pipeline
	typedef struct packed {
		logic        emit;
		logic        do_edge;
		logic [11:0] orow;
		logic [10:0] ocol;
		logic        done;
	} ctl_t;

	// taps in raster order: top row, middle row, bottom row
	localparam coef_t SOBEL_K [NPAIR][TAPS] = '{
		'{-4'sd1, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd1, 4'sd2, 4'sd1},
		'{4'sd1, 4'sd0, -4'sd1, 4'sd2, 4'sd0, -4'sd2, 4'sd1, 4'sd0, -4'sd1}
	};

	localparam coef_t PREWITT_K [NPAIR][TAPS] = '{
		'{-4'sd1, -4'sd1, -4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd1, 4'sd1, 4'sd1},
		'{4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd0, -4'sd1}
	};

	localparam coef_t KIRSCH_K [NKERN][TAPS] = '{
		'{4'sd5, 4'sd5, 4'sd5, -4'sd3, 4'sd0, -4'sd3, -4'sd3, -4'sd3, -4'sd3},
		'{-4'sd3, 4'sd5, 4'sd5, -4'sd3, 4'sd0, 4'sd5, -4'sd3, -4'sd3, -4'sd3},
		'{-4'sd3, -4'sd3, 4'sd5, -4'sd3, 4'sd0, 4'sd5, -4'sd3, -4'sd3, 4'sd5},
		'{-4'sd3, -4'sd3, -4'sd3, -4'sd3, 4'sd0, 4'sd5, -4'sd3, 4'sd5, 4'sd5},
		'{-4'sd3, -4'sd3, -4'sd3, -4'sd3, 4'sd0, -4'sd3, 4'sd5, 4'sd5, 4'sd5},
		'{-4'sd3, -4'sd3, -4'sd3, 4'sd5, 4'sd0, -4'sd3, 4'sd5, 4'sd5, -4'sd3},
		'{4'sd5, -4'sd3, -4'sd3, 4'sd5, 4'sd0, -4'sd3, 4'sd5, -4'sd3, -4'sd3},
		'{4'sd5, 4'sd5, -4'sd3, 4'sd5, 4'sd0, -4'sd3, -4'sd3, -4'sd3, -4'sd3}
	};

	// weighted sum of one kernel over the window, constant coefficients
	function automatic sum_t kdot(input coef_t k [TAPS], input pix_t w [TAPS]);
		sum_t s;
		s = '0;
		for (int t = 0; t < TAPS; t++) begin
			s = s + sum_t'(k[t]) * sum_t'({5'b0, w[t]});
		end
		return s;
	endfunction

endpackage

### src/edge_detect_3x3_max_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_detect_3x3_max_kernel
// 3x3 Sobel / Prewitt / Kirsch edge magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_ready/pixel in raster order, one beat per
// clock. Results leave on out_valid/out_ready with edge_value, out_row,
// out_col and frame_done, lagging the input by frame_width+1 beats; the
// first frame_width+1 beats after reset or a size write produce no result,
// later frames flush the previous frame's border tail with them.
// An accepted beat passes the stage 1, stage 2 and sum stage registers to
// the output register. Throughput is one pixel per clock while not stalled:
// the single line store (upper and middle row per column) is read for the
// incoming beat while the previous beat writes its column back, and all
// kernels of one window are evaluated in parallel over two pipeline stages.
// When out_ready is low with a result pending, the whole pipeline holds and
// in_ready drops; it comes back as soon as the result is taken.
// Reset clears the counters, window and valid bits and sets Sobel, 640x480.
// Line store contents are not cleared; entries are always written before use.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module edge_detect_3x3_max_kernel import ed3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  edge_value,
	output logic [11:0] out_row,
	output logic [10:0] out_col,
	output logic        frame_done
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          adv;
	logic          accept;
	logic [1:0]    mode;
	logic [CW-1:0] col;
	ctl_t          ctl;

	logic          valid_s1;
	pix_t          px_s1;
	logic [CW-1:0] addr_s1;
	ctl_t          ctl_s1;
	logic [15:0]   rd_data;
	pix_t          top_s1;
	pix_t          mid_s1;
	pix_t          win_s1 [TAPS];
	pix_t          wcol_q [6];
	logic          wr_en;

	logic          valid_s2;
	pix_t          win_s2 [TAPS];
	ctl_t          ctl_s2;

	logic          valid_s3;
	ctl_t          ctl_s3;
	pix_t          edge_s3;

	logic          out_valid_q;
	pix_t          edge_q;
	logic [11:0]   row_q;
	logic [10:0]   col_out_q;
	logic          done_q;

	// whole pipeline moves unless a result is stuck at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	ed3_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.mode      (mode),
		.col       (col),
		.ctl       (ctl)
	);

	// line store: read on accept, write back when the beat leaves stage 1
	assign wr_en = valid_s1 && adv;

	ed3_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (16)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata ({mid_s1, px_s1}),
		.re    (accept),
		.raddr (col),
		.rdata (rd_data)
	);

	assign top_s1 = rd_data[15:8];
	assign mid_s1 = rd_data[7:0];

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			addr_s1 <= col;
			ctl_s1  <= ctl;
		end
	end

	// window in raster order, oldest column first
	always_comb begin
		win_s1[0] = wcol_q[0];
		win_s1[1] = wcol_q[3];
		win_s1[2] = top_s1;
		win_s1[3] = wcol_q[1];
		win_s1[4] = wcol_q[4];
		win_s1[5] = mid_s1;
		win_s1[6] = wcol_q[2];
		win_s1[7] = wcol_q[5];
		win_s1[8] = px_s1;
	end

	// window column shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				wcol_q[i] <= '0;
			end
		end else if (wr_en) begin
			wcol_q[0] <= wcol_q[3];
			wcol_q[1] <= wcol_q[4];
			wcol_q[2] <= wcol_q[5];
			wcol_q[3] <= top_s1;
			wcol_q[4] <= mid_s1;
			wcol_q[5] <= px_s1;
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			for (int t = 0; t < TAPS; t++) begin
				win_s2[t] <= win_s1[t];
			end
		end
	end

	ed3_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.win_s2   (win_s2),
		.ctl_s2   (ctl_s2),
		.mode     (mode),
		.valid_s3 (valid_s3),
		.ctl_s3   (ctl_s3),
		.edge_s3  (edge_s3)
	);

	// output register, beats without a result are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3 && ctl_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			edge_q    <= edge_s3;
			row_q     <= ctl_s3.orow;
			col_out_q <= ctl_s3.ocol;
			done_q    <= ctl_s3.done;
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_q;
	assign out_row    = row_q;
	assign out_col    = col_out_q;
	assign frame_done = done_q;

endmodule

### src/ed3_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_line_ram
// Simple dual-port line store, one entry per column holding the upper and
// middle row pixels. Registered read.
// ----------------------------------------------------------------------------
module ed3_line_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ed3_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_scan
// Configuration registers and raster position counters. Works out, for each
// accepted beat, the line store column and whether and where a result leaves.
// ----------------------------------------------------------------------------
module ed3_scan import ed3_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int CW        = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [1:0]    cfg_index,
	input  logic [12:0]   cfg_data,
	input  logic          accept,
	output logic [1:0]    mode,
	output logic [CW-1:0] col,
	output ctl_t          ctl
);

	// wide enough for the column arithmetic and the 12-bit width register
	localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;
	localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);
	localparam logic [WW-1:0] WMIN = WW'(3);

	logic [1:0]    mode_q;
	logic [11:0]   width_q;
	logic [12:0]   height_q;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic          primed_q;

	logic [WW-1:0] eff_w;
	logic [12:0]   eff_h;
	logic [WW-1:0] col_ext;
	logic [WW-1:0] col_m1;
	logic [WW-1:0] w_m1;
	logic [12:0]   h_m1;
	logic [12:0]   h_m2;
	logic [WW-1:0] col_inc;
	logic [12:0]   row_inc;
	logic          col_wrap;
	logic          row_wrap;

	// clamped frame size
	always_comb begin
		eff_w = WW'(width_q);
		if (eff_w < WMIN) begin
			eff_w = WMIN;
		end else if (eff_w > WMAX) begin
			eff_w = WMAX;
		end
		eff_h = height_q;
		if (eff_h < HEIGHT_MIN) begin
			eff_h = HEIGHT_MIN;
		end else if (eff_h > HEIGHT_LIMIT) begin
			eff_h = HEIGHT_LIMIT;
		end
	end

	assign col_ext  = WW'(col_q);
	assign col_m1   = col_ext - WW'(1);
	assign w_m1     = eff_w - WW'(1);
	assign h_m1     = eff_h - 13'd1;
	assign h_m2     = eff_h - 13'd2;
	assign col_inc  = col_ext + WW'(1);
	assign row_inc  = {1'b0, row_q} + 13'd1;
	assign col_wrap = (col_inc >= eff_w);
	assign row_wrap = (row_inc >= eff_h);

	// result position for the beat at the current counters
	always_comb begin
		ctl = '0;
		priority if (row_q != 12'd0 && col_q != '0) begin
			ctl.emit    = 1'b1;
			ctl.orow    = row_q - 12'd1;
			ctl.ocol    = col_m1[10:0];
			ctl.do_edge = (row_q >= 12'd2) && (col_ext >= WW'(2));
		end else if (row_q >= 12'd2) begin
			ctl.emit = 1'b1;
			ctl.orow = row_q - 12'd2;
			ctl.ocol = w_m1[10:0];
		end else if (primed_q) begin
			// border tail of the previous frame
			ctl.emit = 1'b1;
			priority if (row_q == 12'd1) begin
				ctl.orow = h_m1[11:0];
				ctl.ocol = w_m1[10:0];
				ctl.done = 1'b1;
			end else if (col_q != '0) begin
				ctl.orow = h_m1[11:0];
				ctl.ocol = col_m1[10:0];
			end else begin
				ctl.orow = h_m2[11:0];
				ctl.ocol = w_m1[10:0];
			end
		end else begin
			ctl.emit = 1'b0;
		end
	end

	assign mode = mode_q;
	assign col  = col_q;

	// configuration and raster counters; a size write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SOBEL;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				REG_WIDTH: begin
					width_q  <= cfg_data[11:0];
					col_q    <= '0;
					row_q    <= '0;
					primed_q <= 1'b0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
					primed_q <= 1'b0;
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q    <= '0;
					primed_q <= 1'b1;
				end else begin
					row_q <= row_inc[11:0];
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

endmodule

### src/ed3_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_kernel
// Kernel responses over one 3x3 window: sums in one stage, then magnitude,
// Kirsch halving, saturation and the largest response in the next.
// ----------------------------------------------------------------------------
module ed3_kernel import ed3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       valid_s2,
	input  pix_t       win_s2 [TAPS],
	input  ctl_t       ctl_s2,
	input  logic [1:0] mode,
	output logic       valid_s3,
	output ctl_t       ctl_s3,
	output pix_t       edge_s3
);

	sum_t sob [NPAIR];
	sum_t pre [NPAIR];
	sum_t kir [NKERN];
	sum_t sel [NKERN];
	sum_t sum_s3 [NKERN];
	pix_t resp [NKERN];
	pix_t max_l1 [4];
	pix_t max_l2 [2];
	pix_t max_l3;
	logic [12:0] mag [NKERN];

	// all kernel sums in parallel
	always_comb begin
		for (int k = 0; k < NPAIR; k++) begin
			sob[k] = kdot(SOBEL_K[k], win_s2);
			pre[k] = kdot(PREWITT_K[k], win_s2);
		end
		for (int k = 0; k < NKERN; k++) begin
			kir[k] = kdot(KIRSCH_K[k], win_s2);
		end
	end

	// pick the sums of the selected operator, unused kernels read zero
	always_comb begin
		for (int k = 0; k < NKERN; k++) begin
			sel[k] = '0;
		end
		unique case (mode)
			MODE_SOBEL: begin
				for (int k = 0; k < NPAIR; k++) begin
					sel[k] = sob[k];
				end
			end
			MODE_PREWITT: begin
				for (int k = 0; k < NPAIR; k++) begin
					sel[k] = pre[k];
				end
			end
			MODE_KIRSCH: begin
				for (int k = 0; k < NKERN; k++) begin
					sel[k] = kir[k];
				end
			end
			default: begin
				sel[0] = '0;
			end
		endcase
	end

	// sum stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_s2;
			for (int k = 0; k < NKERN; k++) begin
				sum_s3[k] <= sel[k];
			end
		end
	end

	// magnitude, halving and saturation per kernel
	always_comb begin
		for (int k = 0; k < NKERN; k++) begin
			mag[k] = sum_s3[k][12] ? 13'(-sum_s3[k]) : 13'(sum_s3[k]);
			if (mode == MODE_KIRSCH) begin
				mag[k] = mag[k] >> 1;
			end
			resp[k] = (mag[k] > 13'd255) ? 8'hFF : mag[k][7:0];
		end
	end

	// largest response, three compare levels
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			max_l1[i] = (resp[2*i] > resp[2*i+1]) ? resp[2*i] : resp[2*i+1];
		end
		for (int i = 0; i < 2; i++) begin
			max_l2[i] = (max_l1[2*i] > max_l1[2*i+1]) ? max_l1[2*i] : max_l1[2*i+1];
		end
		max_l3 = (max_l2[0] > max_l2[1]) ? max_l2[0] : max_l2[1];
	end

	// border pixels give zero
	assign edge_s3 = ctl_s3.do_edge ? max_l3 : 8'd0;

endmodule

### src/ed3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_checker
// Port-level checks of the edge detector, bound to the top level.
// ----------------------------------------------------------------------------
module ed3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  edge_value,
	input logic [11:0] out_row,
	input logic [10:0] out_col,
	input logic        frame_done
);

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_value) &&
			$stable(out_row) && $stable(out_col) && $stable(frame_done))
		else $error("result beat changed while stalled");

	// input is only refused while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a pending result");

	// top and left border pixels never carry an edge value
	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_value != 8'd0 |-> out_row != 12'd0 && out_col != 11'd0)
		else $error("edge value on top or left border");

	// end of frame carries a zero edge value and a column of at least 2
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> edge_value == 8'd0 && out_col >= 11'd2)
		else $error("frame end on a non-border pixel");

endmodule

bind edge_detect_3x3_max_kernel ed3_checker u_ed3_checker (.*);
